/* hdl/dual_motor_pid_speed_control_assert.svh */
// assertion macros shared by the speed controller rtl
`ifndef DUAL_MOTOR_PID_SPEED_CONTROL_ASSERT_SVH
`define DUAL_MOTOR_PID_SPEED_CONTROL_ASSERT_SVH

// same-cycle implication
`define DMPSC_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define DMPSC_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hdl/dmpsc_pkg.sv */
// types and constants for the dual motor speed controller
package dmpsc_pkg;

  localparam int MUL_A_W   = 35;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = 52;
  localparam int MUL_STEPS = 17;
  localparam int MUL_CNT_W = 5;
  localparam int DIV_N_W   = 34;
  localparam int DIV_D_W   = 18;
  localparam int DIV_STEPS = 34;
  localparam int DIV_CNT_W = 6;
  localparam int SUM_W     = 35;

  localparam logic [6:0]         PCT_SCALE = 7'd100;
  localparam logic signed [31:0] INT_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT_MIN   = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_KFF    = 3'd0,
    REG_KP     = 3'd1,
    REG_KI     = 3'd2,
    REG_KD     = 3'd3,
    REG_PERIOD = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_RADIUS = 3'd6,
    REG_TIMER  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic              new_command;
    logic [2:0]        speed_code;
    logic [7:0]        target_distance;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] left_pulse;
    logic [15:0] right_pulse;
    logic        stop_request;
  } out_item_t;

  typedef struct packed {
    logic                      go;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                      go;
    logic signed [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0]        den;
  } div_req_t;

endpackage

/* hdl/dmpsc_mul.sv */
// bit-serial signed multiplier, one multiplier bit per cycle
module dmpsc_mul (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dmpsc_pkg::mul_req_t                     req,
  output logic                                    done,
  output logic signed [dmpsc_pkg::PROD_W-1:0]     prod
);

  logic [dmpsc_pkg::PROD_W-2:0]    mcand_r;
  logic [dmpsc_pkg::PROD_W-2:0]    acc_r;
  logic [dmpsc_pkg::MUL_B_W-1:0]   mplier_r;
  logic                            neg_r;
  logic                            busy_r;
  logic                            done_r;
  logic [dmpsc_pkg::MUL_CNT_W-1:0] cnt_r;
  logic [dmpsc_pkg::MUL_A_W-1:0]   a_mag;
  logic [dmpsc_pkg::MUL_B_W-1:0]   b_mag;

  // operand magnitudes
  always_comb begin
    a_mag = req.a[dmpsc_pkg::MUL_A_W-1] ? (~req.a + 1'b1) : req.a;
    b_mag = req.b[dmpsc_pkg::MUL_B_W-1] ? (~req.b + 1'b1) : req.b;
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= dmpsc_pkg::MUL_CNT_W'(dmpsc_pkg::MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == dmpsc_pkg::MUL_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift and add
  always_ff @(posedge clk) begin
    if (req.go) begin
      mcand_r  <= (dmpsc_pkg::PROD_W-1)'(a_mag);
      mplier_r <= b_mag;
      acc_r    <= '0;
      neg_r    <= req.a[dmpsc_pkg::MUL_A_W-1] ^ req.b[dmpsc_pkg::MUL_B_W-1];
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign done = done_r;
  assign prod = neg_r ? -$signed({1'b0, acc_r}) : $signed({1'b0, acc_r});

endmodule

/* hdl/dmpsc_div.sv */
// restoring divider, one quotient bit per cycle, truncates toward zero
module dmpsc_div (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  dmpsc_pkg::div_req_t                     req,
  output logic                                    done,
  output logic signed [dmpsc_pkg::DIV_N_W-1:0]    quo
);

  logic [dmpsc_pkg::DIV_N_W-1:0]   quo_r;
  logic [dmpsc_pkg::DIV_D_W-1:0]   rem_r;
  logic [dmpsc_pkg::DIV_D_W-1:0]   den_r;
  logic                            neg_r;
  logic                            busy_r;
  logic                            done_r;
  logic [dmpsc_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [dmpsc_pkg::DIV_N_W-1:0]   num_mag;
  logic [dmpsc_pkg::DIV_D_W:0]     trial;
  logic [dmpsc_pkg::DIV_D_W:0]     diff;
  logic                            ge;

  // magnitude and trial subtract
  always_comb begin
    num_mag = req.num[dmpsc_pkg::DIV_N_W-1] ? (~req.num + 1'b1) : req.num;
    trial   = {rem_r, quo_r[dmpsc_pkg::DIV_N_W-1]};
    diff    = trial - {1'b0, den_r};
    ge      = (trial >= {1'b0, den_r});
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= dmpsc_pkg::DIV_CNT_W'(dmpsc_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == dmpsc_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= req.den;
      neg_r <= req.num[dmpsc_pkg::DIV_N_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? diff[dmpsc_pkg::DIV_D_W-1:0] : trial[dmpsc_pkg::DIV_D_W-1:0];
      quo_r <= {quo_r[dmpsc_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

/* hdl/dual_motor_pid_speed_control.sv */
// two-motor pid speed controller with feedforward, clamp and pwm mapping
//
// Input channel in_valid/in_ready/in_data carries one control tick: two wheel
// speeds and an optional new command. Result channel out_valid/out_ready/
// out_data returns one transaction per tick: the two applied pwm compare values
// and the stop request. The user writes gains and limits through cfg_we/
// cfg_index/cfg_data only while the block is idle; it does not enforce this.
// One tick is worked through a sequencer that feeds a shared bit-serial
// multiplier (17 steps) and a shared restoring divider (34 steps): six
// products and three quotients per motor plus two products for the
// distance, one product and one quotient fewer per motor with a zero drive
// limit; ticks are handled one at a time, and in_ready returns in the
// same cycle as out_valid rises, when the result is loaded.
// The finished result sits in an output register; the next tick is taken
// while it waits, and if that tick finishes before the receiver takes the
// waiting result the sequencer holds until it does.
// Reset (rst_n low at a clock edge) restores the register defaults and clears
// the reference, integrators, previous speeds, distance and both pulses.
`include "dual_motor_pid_speed_control_assert.svh"

module dual_motor_pid_speed_control (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmpsc_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmpsc_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_ERR   = 15'b000000000000010,
    S_P     = 15'b000000000000100,
    S_EDT   = 15'b000000000001000,
    S_I     = 15'b000000000010000,
    S_D     = 15'b000000000100000,
    S_DD    = 15'b000000001000000,
    S_CLAMP = 15'b000000010000000,
    S_UM    = 15'b000000100000000,
    S_UD    = 15'b000001000000000,
    S_CM    = 15'b000010000000000,
    S_CD    = 15'b000100000000000,
    S_DM1   = 15'b001000000000000,
    S_DM2   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [15:0] kff_r, kp_r, ki_r, kd_r;
  logic [9:0]         period_r;
  logic [15:0]        limit_r, radius_r, timer_r;

  // controller state
  logic [1:0]         ref_code_r, last_code_r;
  logic signed [31:0] integ_r [2];
  logic signed [15:0] prev_r [2];
  logic [15:0]        travelled_r;
  logic [7:0]         goal_r;
  logic               track_r;
  logic [15:0]        pulse_r [2];

  // per-tick working registers
  dmpsc_pkg::in_item_t            in_r;
  logic                           m_r;
  logic signed [16:0]             err_r;
  logic signed [dmpsc_pkg::SUM_W-1:0] sum_r;
  logic                           stop_r;
  dmpsc_pkg::out_item_t           out_r;
  logic                           out_valid_r;

  // shared arithmetic units
  dmpsc_pkg::mul_req_t            mul_req_r;
  dmpsc_pkg::div_req_t            div_req_r;
  logic                           mul_done, div_done;
  logic signed [dmpsc_pkg::PROD_W-1:0]  mul_prod;
  logic signed [dmpsc_pkg::DIV_N_W-1:0] div_quo;

  dmpsc_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req_r),
    .done (mul_done),
    .prod (mul_prod)
  );

  dmpsc_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req_r),
    .done (div_done),
    .quo  (div_quo)
  );

  // combinational helpers
  logic [9:0]                          dt;
  logic signed [15:0]                  spd;
  logic signed [16:0]                  err_nxt;
  logic signed [17:0]                  ff;
  logic signed [33:0]                  acc_nxt;
  logic signed [dmpsc_pkg::PROD_W-1:0] prod_sh8;
  logic signed [31:0]                  isat;
  logic signed [16:0]                  diff;
  logic [15:0]                         u_nxt;
  logic [16:0]                         timer_p1;
  logic [15:0]                         cmp;
  logic signed [dmpsc_pkg::PROD_W-1:0] prod_sh24;
  logic [15:0]                         inc;
  logic [16:0]                         trav_sum;
  logic [15:0]                         trav_nxt;
  logic                                code_ok;

  always_comb begin
    dt       = (period_r == '0) ? 10'd1 : period_r;
    spd      = m_r ? in_r.right_speed : in_r.left_speed;
    err_nxt  = $signed({7'b0, ref_code_r, 8'b0}) - 17'(spd);
    ff       = (ref_code_r[1] ? (18'(kff_r) <<< 1) : 18'sd0)
             + (ref_code_r[0] ? 18'(kff_r) : 18'sd0);
    acc_nxt  = 34'(integ_r[m_r]) + 34'(mul_prod);
    prod_sh8 = mul_prod >>> 8;
    // integrator saturates at 32 bits
    if (prod_sh8 > dmpsc_pkg::PROD_W'(dmpsc_pkg::INT_MAX)) begin
      isat = dmpsc_pkg::INT_MAX;
    end else if (prod_sh8 < dmpsc_pkg::PROD_W'(dmpsc_pkg::INT_MIN)) begin
      isat = dmpsc_pkg::INT_MIN;
    end else begin
      isat = prod_sh8[31:0];
    end
    diff = 17'(spd) - 17'(prev_r[m_r]);
    // drive clamp to zero and the limit
    if (sum_r < 0) begin
      u_nxt = 16'd0;
    end else if (sum_r > $signed({19'b0, limit_r})) begin
      u_nxt = limit_r;
    end else begin
      u_nxt = sum_r[15:0];
    end
    timer_p1 = {1'b0, timer_r} + 17'd1;
    cmp      = div_quo[15:0] - 16'd1;
    // distance increment, reverse motion adds nothing
    prod_sh24 = mul_prod >>> 24;
    if (mul_prod < 0) begin
      inc = 16'd0;
    end else if (|prod_sh24[dmpsc_pkg::PROD_W-1:16]) begin
      inc = 16'hFFFF;
    end else begin
      inc = prod_sh24[15:0];
    end
    trav_sum = {1'b0, travelled_r} + {1'b0, inc};
    trav_nxt = trav_sum[16] ? 16'hFFFF : trav_sum[15:0];
    code_ok  = !in_data.speed_code[2] && (in_data.speed_code[1:0] != 2'd0);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kff_r    <= 16'sd256;
      kp_r     <= 16'sd0;
      ki_r     <= 16'sd0;
      kd_r     <= 16'sd0;
      period_r <= 10'd50;
      limit_r  <= 16'd3072;
      radius_r <= 16'd2163;
      timer_r  <= 16'd15999;
    end else if (cfg_we) begin
      unique case (dmpsc_pkg::cfg_reg_t'(cfg_index))
        dmpsc_pkg::REG_KFF:    kff_r    <= $signed(cfg_data);
        dmpsc_pkg::REG_KP:     kp_r     <= $signed(cfg_data);
        dmpsc_pkg::REG_KI:     ki_r     <= $signed(cfg_data);
        dmpsc_pkg::REG_KD:     kd_r     <= $signed(cfg_data);
        dmpsc_pkg::REG_PERIOD: period_r <= cfg_data[9:0];
        dmpsc_pkg::REG_LIMIT:  limit_r  <= cfg_data;
        dmpsc_pkg::REG_RADIUS: radius_r <= cfg_data;
        dmpsc_pkg::REG_TIMER:  timer_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ref_code_r   <= 2'd0;
      last_code_r  <= 2'd0;
      integ_r[0]   <= '0;
      integ_r[1]   <= '0;
      prev_r[0]    <= '0;
      prev_r[1]    <= '0;
      travelled_r  <= '0;
      goal_r       <= '0;
      track_r      <= 1'b0;
      pulse_r[0]   <= '0;
      pulse_r[1]   <= '0;
      out_valid_r  <= 1'b0;
      mul_req_r.go <= 1'b0;
      div_req_r.go <= 1'b0;
      m_r          <= 1'b0;
    end else begin
      mul_req_r.go <= 1'b0;
      div_req_r.go <= 1'b0;
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            in_r <= in_data;
            m_r  <= 1'b0;
            if (in_data.new_command) begin
              goal_r      <= in_data.target_distance;
              track_r     <= (in_data.target_distance != 8'd0);
              travelled_r <= '0;
              integ_r[0]  <= '0;
              integ_r[1]  <= '0;
              prev_r[0]   <= '0;
              prev_r[1]   <= '0;
              if (code_ok) begin
                ref_code_r  <= in_data.speed_code[1:0];
                last_code_r <= in_data.speed_code[1:0];
              end else begin
                ref_code_r  <= last_code_r;
              end
            end
            state_r <= S_ERR;
          end
        end
        S_ERR: begin
          err_r       <= err_nxt;
          sum_r       <= dmpsc_pkg::SUM_W'(ff);
          mul_req_r   <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(err_nxt), b: 17'(kp_r)};
          state_r     <= S_P;
        end
        S_P: begin
          if (mul_done) begin
            sum_r     <= sum_r + dmpsc_pkg::SUM_W'(prod_sh8);
            mul_req_r <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(err_r),
                           b: $signed({7'b0, dt})};
            state_r   <= S_EDT;
          end
        end
        S_EDT: begin
          if (mul_done) begin
            mul_req_r <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(acc_nxt), b: 17'(ki_r)};
            state_r   <= S_I;
          end
        end
        S_I: begin
          if (mul_done) begin
            integ_r[m_r] <= isat;
            sum_r        <= sum_r + dmpsc_pkg::SUM_W'(isat);
            prev_r[m_r]  <= spd;
            mul_req_r    <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(diff), b: 17'(kd_r)};
            state_r      <= S_D;
          end
        end
        S_D: begin
          if (mul_done) begin
            div_req_r <= '{go: 1'b1, num: dmpsc_pkg::DIV_N_W'(mul_prod),
                           den: {dt, 8'b0}};
            state_r   <= S_DD;
          end
        end
        S_DD: begin
          if (div_done) begin
            sum_r   <= sum_r - dmpsc_pkg::SUM_W'(div_quo);
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          // zero limit gives zero duty
          if (limit_r == '0) begin
            mul_req_r <= '{go: 1'b1, a: $signed({18'b0, timer_p1}), b: 17'sd0};
            state_r   <= S_CM;
          end else begin
            mul_req_r <= '{go: 1'b1, a: $signed({19'b0, u_nxt}),
                           b: $signed({10'b0, dmpsc_pkg::PCT_SCALE})};
            state_r   <= S_UM;
          end
        end
        S_UM: begin
          if (mul_done) begin
            div_req_r <= '{go: 1'b1, num: dmpsc_pkg::DIV_N_W'(mul_prod),
                           den: {2'b0, limit_r}};
            state_r   <= S_UD;
          end
        end
        S_UD: begin
          if (div_done) begin
            mul_req_r <= '{go: 1'b1, a: $signed({18'b0, timer_p1}),
                           b: $signed({10'b0, div_quo[6:0]})};
            state_r   <= S_CM;
          end
        end
        S_CM: begin
          if (mul_done) begin
            div_req_r <= '{go: 1'b1, num: dmpsc_pkg::DIV_N_W'(mul_prod),
                           den: {11'b0, dmpsc_pkg::PCT_SCALE}};
            state_r   <= S_CD;
          end
        end
        S_CD: begin
          if (div_done) begin
            // out-of-range compare keeps the old pulse
            if (cmp <= timer_r) begin
              pulse_r[m_r] <= cmp;
            end
            if (!m_r) begin
              m_r     <= 1'b1;
              state_r <= S_ERR;
            end else if (track_r) begin
              mul_req_r <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(in_r.left_speed),
                             b: $signed({1'b0, radius_r})};
              state_r   <= S_DM1;
            end else begin
              stop_r  <= 1'b0;
              state_r <= S_OUT;
            end
          end
        end
        S_DM1: begin
          if (mul_done) begin
            mul_req_r <= '{go: 1'b1, a: dmpsc_pkg::MUL_A_W'(mul_prod),
                           b: $signed({7'b0, dt})};
            state_r   <= S_DM2;
          end
        end
        S_DM2: begin
          if (mul_done) begin
            travelled_r <= trav_nxt;
            stop_r      <= (trav_nxt >= {8'b0, goal_r});
            state_r     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r       <= '{left_pulse: pulse_r[0], right_pulse: pulse_r[1],
                             stop_request: stop_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `DMPSC_ASSERT_IMP(a_one_launch, mul_req_r.go, !div_req_r.go, "multiplier and divider launched together")
  `DMPSC_ASSERT_NXT(a_accept_starts, in_valid && in_ready, state_r == S_ERR, "accepted tick did not start")
  `DMPSC_ASSERT_IMP(a_idle_quiet, state_r == S_IDLE, !mul_done && !div_done, "unit finished while idle")
  `DMPSC_ASSERT_NXT(a_result_loaded, (state_r == S_OUT) && (!out_valid_r || out_ready), out_valid_r && (state_r == S_IDLE), "result not loaded")

endmodule

/* tb/dual_motor_pid_speed_control_tb.sv */
// testbench for the dual motor pid speed controller
`timescale 1ns / 100ps

module dual_motor_pid_speed_control_tb;

  // software copy of the controller used to predict each tick
  class pulse_scoreboard;
    logic [15:0] kff, kp, ki, kd, lim, radius, tmr;
    logic [9:0]  period;
    longint      ref_spd, last_ref;
    int          integ [2];
    longint      prev_spd [2];
    longint      travelled;
    int          goal;
    bit          tracking;
    logic [15:0] pulse [2];
    dmpsc_pkg::out_item_t pending [$];
    int          errors;

    function void reset_state();
      kff = 16'd256; kp = '0; ki = '0; kd = '0; period = 10'd50;
      lim = 16'd3072; radius = 16'd2163; tmr = 16'd15999;
      ref_spd = 0; last_ref = 0; integ = '{0, 0}; prev_spd = '{0, 0};
      travelled = 0; goal = 0; tracking = 0; pulse = '{16'd0, 16'd0};
      errors = 0;
    endfunction

    function void write_reg(dmpsc_pkg::cfg_reg_t idx, logic [15:0] v);
      case (idx)
        dmpsc_pkg::REG_KFF:    kff = v;
        dmpsc_pkg::REG_KP:     kp = v;
        dmpsc_pkg::REG_KI:     ki = v;
        dmpsc_pkg::REG_KD:     kd = v;
        dmpsc_pkg::REG_PERIOD: period = v[9:0];
        dmpsc_pkg::REG_LIMIT:  lim = v;
        dmpsc_pkg::REG_RADIUS: radius = v;
        dmpsc_pkg::REG_TIMER:  tmr = v;
        default: ;
      endcase
    endfunction

    // arithmetic shift gives floor division by 256
    function void drive(longint mea, int m);
      longint dt, err, ff, p, acc, i, d, u, duty, cmp;
      dt = (period == 0) ? 1 : longint'(period);
      err = ref_spd - mea;
      ff = (longint'($signed(kff)) * ref_spd) >>> 8;
      p = (longint'($signed(kp)) * err) >>> 8;
      acc = longint'(integ[m]) + err * dt;
      i = (longint'($signed(ki)) * acc) >>> 8;
      d = (longint'($signed(kd)) * (mea - prev_spd[m])) / (256 * dt);
      if (i > 64'sd2147483647) i = 64'sd2147483647;
      if (i < -64'sd2147483648) i = -64'sd2147483648;
      integ[m] = int'(i);
      u = ff + p + i - d;
      if (u < 0) u = 0;
      if (u > longint'(lim)) u = lim;
      duty = (lim != 0) ? (u * 100) / lim : 0;
      cmp = (((longint'(tmr) + 1) * duty) / 100 - 1) & 64'hFFFF;
      if (cmp <= longint'(tmr)) pulse[m] = cmp[15:0];
    endfunction

    function void note_tick(dmpsc_pkg::in_item_t t);
      longint l, r, inc;
      dmpsc_pkg::out_item_t o;
      l = t.left_speed; r = t.right_speed;
      if (t.new_command) begin
        goal = t.target_distance; tracking = (goal != 0); travelled = 0;
        integ = '{0, 0}; prev_spd = '{0, 0};
        if (t.speed_code >= 1 && t.speed_code <= 3) begin
          ref_spd = t.speed_code * 256; last_ref = ref_spd;
        end else ref_spd = last_ref;
      end
      drive(l, 0);
      drive(r, 1);
      prev_spd = '{l, r};
      o.stop_request = 0;
      if (tracking) begin
        inc = (l * longint'(radius) * ((period == 0) ? 1 : longint'(period))) / (64'sd1 << 24);
        if (inc < 0) inc = 0;
        if (inc > 65535) inc = 65535;
        travelled += inc;
        if (travelled > 65535) travelled = 65535;
        o.stop_request = (travelled >= goal);
      end
      o.left_pulse = pulse[0]; o.right_pulse = pulse[1];
      pending.push_back(o);
    endfunction

    function void check_result(dmpsc_pkg::out_item_t got);
      dmpsc_pkg::out_item_t exp_o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
        return;
      end
      exp_o = pending.pop_front();
      if (got.left_pulse !== exp_o.left_pulse) begin
        $display("%0t: left_pulse exp %0d got %0d", $realtime, exp_o.left_pulse, got.left_pulse);
        errors++;
      end
      if (got.right_pulse !== exp_o.right_pulse) begin
        $display("%0t: right_pulse exp %0d got %0d", $realtime, exp_o.right_pulse,
                 got.right_pulse);
        errors++;
      end
      if (got.stop_request !== exp_o.stop_request) begin
        $display("%0t: stop_request exp %0b got %0b", $realtime, exp_o.stop_request,
                 got.stop_request);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_ready, out_valid, out_ready;
  dmpsc_pkg::in_item_t  in_data;
  dmpsc_pkg::out_item_t out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  pulse_scoreboard sb;
  int  send_idle_pct, recv_stall_pct;
  int  quiet_cycles;
  bit  timed_out;

  localparam int WATCHDOG_LIMIT = 20000;

  dual_motor_pid_speed_control u_top (.*);

  // clock
  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // result side: random stall, check on accept
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // valid stays high between back-to-back ticks
  task automatic send_tick(dmpsc_pkg::in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cfg(dmpsc_pkg::cfg_reg_t idx, logic [15:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    sb.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic dmpsc_pkg::in_item_t make_tick(bit cmd, logic [2:0] code,
                                                    logic [7:0] tgt_dist,
                                                    logic [15:0] l, logic [15:0] r);
    dmpsc_pkg::in_item_t t;
    t.new_command = cmd; t.speed_code = code; t.target_distance = tgt_dist;
    t.left_speed = l; t.right_speed = r;
    return t;
  endfunction

  // moderate speeds give useful drive; sometimes full range
  function automatic logic [15:0] rand_speed();
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(2047)) - 1024);
  endfunction

  task automatic random_ticks(int n);
    bit cmd;
    for (int k = 0; k < n; k++) begin
      cmd = ($urandom_range(9) == 0);
      send_tick(make_tick(cmd, 3'($urandom_range(7)), 8'($urandom_range(255)),
                          rand_speed(), rand_speed()));
    end
  endtask

  task automatic random_gains();
    write_cfg(dmpsc_pkg::REG_KFF, 16'($signed($urandom_range(1024)) - 256));
    write_cfg(dmpsc_pkg::REG_KP, 16'($signed($urandom_range(1024)) - 256));
    write_cfg(dmpsc_pkg::REG_KI, 16'($signed($urandom_range(256)) - 64));
    write_cfg(dmpsc_pkg::REG_KD, 16'($signed($urandom_range(512)) - 128));
    write_cfg(dmpsc_pkg::REG_PERIOD, 16'($urandom_range(1023)));
    write_cfg(dmpsc_pkg::REG_LIMIT, 16'($urandom_range(65535)));
    write_cfg(dmpsc_pkg::REG_RADIUS, 16'($urandom));
    write_cfg(dmpsc_pkg::REG_TIMER,
              ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom_range(65535)));
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    send_idle_pct = 0; recv_stall_pct = 0;
    rst_n <= 1'b0; in_valid <= 1'b0; in_data <= '0;
    cfg_we <= 1'b0; cfg_index <= dmpsc_pkg::REG_KFF; cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset gains, valid and invalid speed codes, extremes, reverse motion
    send_tick(make_tick(1, 3'd0, 8'd0, 16'h0000, 16'h0000));
    send_tick(make_tick(1, 3'd1, 8'd255, 16'h7FFF, 16'h8000));
    send_tick(make_tick(1, 3'd2, 8'd1, 16'h8000, 16'h7FFF));
    send_tick(make_tick(1, 3'd3, 8'd5, 16'h0100, 16'h0200));
    send_tick(make_tick(0, 3'd7, 8'd0, 16'h7FFF, 16'h0000));
    send_tick(make_tick(1, 3'd4, 8'd10, 16'h0300, 16'h0300));
    send_tick(make_tick(1, 3'd7, 8'd0, 16'hFFFF, 16'h0001));
    send_tick(make_tick(1, 3'd5, 8'd3, 16'h8000, 16'h8000));
    wait_drained();

    // zero period, zero limit, full timer, strong gains
    write_cfg(dmpsc_pkg::REG_PERIOD, 16'd0);
    write_cfg(dmpsc_pkg::REG_LIMIT, 16'd0);
    write_cfg(dmpsc_pkg::REG_TIMER, 16'hFFFF);
    write_cfg(dmpsc_pkg::REG_KP, 16'h7FFF);
    write_cfg(dmpsc_pkg::REG_KI, 16'h8000);
    write_cfg(dmpsc_pkg::REG_KD, 16'h7FFF);
    write_cfg(dmpsc_pkg::REG_RADIUS, 16'hFFFF);
    send_tick(make_tick(1, 3'd3, 8'd200, 16'h7FFF, 16'h8000));
    send_tick(make_tick(0, 3'd0, 8'd0, 16'h8000, 16'h7FFF));
    wait_drained();
    write_cfg(dmpsc_pkg::REG_LIMIT, 16'hFFFF);
    write_cfg(dmpsc_pkg::REG_PERIOD, 16'd1023);
    write_cfg(dmpsc_pkg::REG_KFF, 16'h8000);
    send_tick(make_tick(1, 3'd2, 8'd255, 16'h7FFF, 16'h0000));
    send_tick(make_tick(0, 3'd0, 8'd0, 16'h8000, 16'h8000));
    send_tick(make_tick(0, 3'd0, 8'd0, 16'h7FFF, 16'h7FFF));
    wait_drained();
    write_cfg(dmpsc_pkg::REG_TIMER, 16'd1);
    write_cfg(dmpsc_pkg::REG_KFF, 16'h7FFF);
    write_cfg(dmpsc_pkg::REG_RADIUS, 16'd0);
    send_tick(make_tick(1, 3'd1, 8'd4, 16'h0100, 16'h0080));
    send_tick(make_tick(0, 3'd1, 8'd4, 16'h0100, 16'h0080));
    wait_drained();

    // random phases with varied idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      wait_drained();
      random_gains();
      random_ticks(64);
    end
    send_idle_pct = 0; recv_stall_pct = 0;
    wait_drained();

    if (sb.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
